FILE: rtl/afs_pkg.sv
package afs_pkg;

  localparam int TS_W           = 48;
  localparam int DUR_W          = 32;
  localparam int ACT_W          = 2;
  localparam int ST_W           = 2;
  localparam int OUT_IDX_W      = 6;
  localparam int MAX_FRAMES_DEF = 64;

  localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

  localparam logic [ST_W-1:0] ST_DONE    = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 2'd1;
  localparam logic [ST_W-1:0] ST_IGNORED = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage

FILE: rtl/afs_mod_unit.sv
module afs_mod_unit #(
  parameter int CT_W = afs_pkg::DUR_W + $clog2(afs_pkg::MAX_FRAMES_DEF)
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [afs_pkg::TS_W-1:0]  dividend,
  input  logic [CT_W-1:0]           divisor,
  output logic [CT_W-1:0]           remainder,
  output afs_pkg::mod_stat_t        stat
);
  import afs_pkg::*;

  localparam int CNT_W = $clog2(TS_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TS_W-1:0]   dvd_r, dvd_nxt;
  logic [CT_W-1:0]   rem_r, rem_nxt;
  logic [CT_W:0]     rem_sh;
  logic [CT_W:0]     rem_diff;
  logic              fits;

  assign rem_sh   = {rem_r, dvd_r[TS_W-1]};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dvd_nxt  = dividend;
      rem_nxt  = '0;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[TS_W-2:0], 1'b0};
      rem_nxt = fits ? rem_diff[CT_W-1:0] : rem_sh[CT_W-1:0];
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(TS_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign remainder = rem_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule

FILE: rtl/animation_frame_sequencer.sv
// Each request either appends a frame duration, clears the frame table, or
// updates the current frame from an absolute timestamp, and returns exactly one
// result with the frame index, the phase within that frame and a status. Appends,
// clears, unused codes and ignored updates return their result in the cycle
// after the request is taken. A live update runs the elapsed time through a
// bit-serial remainder unit that takes one dividend bit at a time, adds the old
// phase, then walks the duration table one frame per cycle through the
// registered memory read port. No new request is taken while an update is in
// progress. The table needs no clearing pass after reset, so requests are taken
// from the first cycle.
module animation_frame_sequencer #(
  parameter int MAX_FRAMES = afs_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [afs_pkg::ACT_W-1:0]     in_action,
  input  logic [afs_pkg::TS_W-1:0]      in_timestamp,
  input  logic [afs_pkg::DUR_W-1:0]     in_frame_duration,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [afs_pkg::OUT_IDX_W-1:0] out_frame_index,
  output logic [afs_pkg::DUR_W-1:0]     out_phase_in_frame,
  output logic [afs_pkg::ST_W-1:0]      out_status
);
  import afs_pkg::*;

  localparam int IDX_W     = $clog2(MAX_FRAMES);
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int CT_W      = DUR_W + IDX_W;
  localparam int ACC_W     = CT_W + 1;
  localparam int GUARD_MAX = 2 * MAX_FRAMES + 2;
  localparam int GUARD_W   = $clog2(GUARD_MAX + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MOD  = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [DUR_W-1:0] mem [MAX_FRAMES];
  logic [DUR_W-1:0] rd_data_r;

  logic [1:0]           state_r, state_nxt;
  logic [CNT_W-1:0]     loaded_r, loaded_nxt;
  logic [CT_W-1:0]      total_r, total_nxt;
  logic [IDX_W-1:0]     idx_r, idx_nxt;
  logic [DUR_W-1:0]     phase_r, phase_nxt;
  logic [TS_W-1:0]      last_ts_r, last_ts_nxt;
  logic [TS_W-1:0]      ts_r, ts_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [GUARD_W-1:0]   guard_r, guard_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [DUR_W-1:0]     out_phase_r, out_phase_nxt;
  logic [ST_W-1:0]      out_status_r, out_status_nxt;

  logic             in_accept;
  logic             is_ignored;
  logic             table_full;
  logic             do_append;
  logic             mod_start;
  logic [TS_W-1:0]  elapsed;
  logic [IDX_W-1:0] cur_sel;
  logic [IDX_W-1:0] next_sel;
  logic [CNT_W-1:0] cur_inc;
  logic [IDX_W-1:0] rd_addr;
  logic [ACC_W-1:0] rd_dur_ext;
  logic             walk_stop;
  logic [CT_W-1:0]  mod_rem;
  mod_stat_t        mod_stat;

  assign in_stall   = (state_r != S_IDLE) | (out_valid_r & out_stall);
  assign in_accept  = in_valid & ~in_stall;
  assign is_ignored = (in_timestamp <= last_ts_r) || (total_r == '0) || (loaded_r == '0);
  assign table_full = loaded_r >= CNT_W'(MAX_FRAMES);
  assign do_append  = in_accept && (in_action == ACT_APPEND) && !table_full;
  assign mod_start  = in_accept && (in_action == ACT_UPDATE) && !is_ignored;
  assign elapsed    = in_timestamp - last_ts_r;

  assign cur_sel    = (CNT_W'(idx_r) < loaded_r) ? idx_r : '0;
  assign cur_inc    = CNT_W'(cur_sel) + CNT_W'(1);
  assign next_sel   = (cur_inc >= loaded_r) ? '0 : cur_inc[IDX_W-1:0];
  assign rd_dur_ext = ACC_W'(rd_data_r);
  assign walk_stop  = (acc_r < rd_dur_ext) || (guard_r == GUARD_W'(GUARD_MAX));
  assign rd_addr    = ((state_r == S_WALK) && !walk_stop) ? next_sel : cur_sel;

  afs_mod_unit #(
    .CT_W(CT_W)
  ) u_mod (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (mod_start),
    .dividend  (elapsed),
    .divisor   (total_r),
    .remainder (mod_rem),
    .stat      (mod_stat)
  );

  always_ff @(posedge clk) begin
    if (do_append) begin
      mem[loaded_r[IDX_W-1:0]] <= in_frame_duration;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    loaded_nxt     = loaded_r;
    total_nxt      = total_r;
    idx_nxt        = idx_r;
    phase_nxt      = phase_r;
    last_ts_nxt    = last_ts_r;
    ts_nxt         = ts_r;
    acc_nxt        = acc_r;
    guard_nxt      = guard_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_idx_nxt    = out_idx_r;
    out_phase_nxt  = out_phase_r;
    out_status_nxt = out_status_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          out_idx_nxt    = OUT_IDX_W'(idx_r);
          out_phase_nxt  = phase_r;
          out_status_nxt = ST_DONE;
          out_valid_nxt  = 1'b1;
          case (in_action)
            ACT_UPDATE: begin
              if (is_ignored) begin
                out_status_nxt = ST_IGNORED;
              end else begin
                out_valid_nxt = 1'b0;
                ts_nxt        = in_timestamp;
                state_nxt     = S_MOD;
              end
            end
            ACT_APPEND: begin
              if (table_full) begin
                out_status_nxt = ST_FULL;
              end else begin
                loaded_nxt = loaded_r + CNT_W'(1);
                total_nxt  = total_r + CT_W'(in_frame_duration);
              end
            end
            ACT_CLEAR: begin
              loaded_nxt    = '0;
              total_nxt     = '0;
              idx_nxt       = '0;
              phase_nxt     = '0;
              out_idx_nxt   = '0;
              out_phase_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      S_MOD: begin
        if (mod_stat.done) begin
          acc_nxt   = ACC_W'(mod_rem) + ACC_W'(phase_r);
          guard_nxt = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (walk_stop) begin
          phase_nxt      = acc_r[DUR_W-1:0];
          last_ts_nxt    = ts_r;
          out_idx_nxt    = OUT_IDX_W'(idx_r);
          out_phase_nxt  = acc_r[DUR_W-1:0];
          out_status_nxt = ST_DONE;
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
        end else begin
          acc_nxt   = acc_r - rd_dur_ext;
          idx_nxt   = next_sel;
          guard_nxt = guard_r + GUARD_W'(1);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      total_r     <= '0;
      idx_r       <= '0;
      phase_r     <= '0;
      last_ts_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      total_r     <= total_nxt;
      idx_r       <= idx_nxt;
      phase_r     <= phase_nxt;
      last_ts_r   <= last_ts_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ts_r         <= ts_nxt;
    acc_r        <= acc_nxt;
    guard_r      <= guard_nxt;
    out_idx_r    <= out_idx_nxt;
    out_phase_r  <= out_phase_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_frame_index    = out_idx_r;
  assign out_phase_in_frame = out_phase_r;
  assign out_status         = out_status_r;

  // A busy sequencer never has a result waiting, so no result can be overwritten.
  a_busy_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> !out_valid_r)
    else $error("result pending while an update is in progress");

  a_request_answered: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (out_valid_r || (state_r == S_MOD)))
    else $error("request taken without a result or an update in progress");

  a_mod_running: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOD) |-> (mod_stat.busy || mod_stat.done))
    else $error("waiting on an idle remainder unit");

  a_walk_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> ((loaded_r != '0) && (total_r != '0)))
    else $error("frame walk with an empty cycle");

  a_state_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |=> $stable(loaded_r) && $stable(total_r))
    else $error("table changed during an update");

endmodule
